// ===== src/mclp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mclp_pkg
// Shared types and constants of the motor command line parser: channel
// payloads, character codes, command kinds and divider request/response.
// ============================================================================
package mclp_pkg;

    // Field widths
    localparam int PERIOD_W    = 13;
    localparam int DUTY_W      = 15;
    localparam int STEER_W     = 12;
    localparam int ACC_W       = 20;
    localparam int POS_W       = 8;
    localparam int KIND_W      = 3;
    localparam int MUL_A_W     = 12;
    localparam int MUL_B_W     = 15;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int DIVISOR_W   = 10;
    localparam int RECIP_W     = 28;
    localparam int RECIP_SHIFT = PROD_W + DIVISOR_W;

    // Register reset and arithmetic constants
    localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 13'd5000;
    localparam logic [DIVISOR_W-1:0] SCALE_DIV    = 10'd1023;
    localparam logic [DIVISOR_W-1:0] MIX_DIV      = 10'd1000;
    localparam logic [STEER_W-1:0]   MIX_CENTER   = 12'd1000;
    localparam logic [ACC_W-1:0]     P_LIMIT      = 20'd1024;
    localparam logic [ACC_W-1:0]     X_LIMIT      = 20'd3000;
    localparam logic [POS_W-1:0]     MIN_LEN      = 8'd4;
    localparam logic [POS_W-1:0]     DIGIT_POS    = 8'd4;

    // Reciprocals 2^RECIP_SHIFT / divisor, rounded up; exact for any
    // dividend below 2^PROD_W
    localparam logic [RECIP_W-1:0]   RECIP_SCALE  = 28'd134348929;
    localparam logic [RECIP_W-1:0]   RECIP_MIX    = 28'd137438954;

    // Character codes
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_C    = 8'h63;
    localparam logic [7:0] CHAR_P    = 8'h70;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_L    = 8'h6C;
    localparam logic [7:0] CHAR_D    = 8'h64;

    // Command kinds reported with each line
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DIRECT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MIXED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LIGHT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DIR     = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       packet_end;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic              light_enable;
        logic              reverse_dir;
        logic [KIND_W-1:0] command_kind;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [PROD_W-1:0]    dividend;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/mclp_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mclp_div
// Constant divider by reciprocal multiply. Takes a product and one of the two
// constant divisors on start, registers them, multiplies by the reciprocal
// into the product register and pulses done with the quotient.
// ============================================================================
module mclp_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  mclp_pkg::div_req_t  req,
    output mclp_pkg::div_rsp_t  rsp
);

    logic                                              done_reg;
    logic                                              mul_pend_reg;
    logic [mclp_pkg::PROD_W-1:0]                       dvd_reg;
    logic [mclp_pkg::RECIP_W-1:0]                      recip_reg;
    logic [mclp_pkg::PROD_W+mclp_pkg::RECIP_W-1:0]     prod_reg;

    logic [mclp_pkg::RECIP_W-1:0]                      recip_sel;

    // Pick the reciprocal of the requested divisor
    assign recip_sel = (req.divisor == mclp_pkg::MIX_DIV) ? mclp_pkg::RECIP_MIX :
                                                            mclp_pkg::RECIP_SCALE;

    // Load on start, multiply by the reciprocal in the next cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg     <= 1'b0;
            mul_pend_reg <= 1'b0;
        end else begin
            done_reg     <= mul_pend_reg;
            mul_pend_reg <= req.start;
            if (req.start) begin
                dvd_reg   <= req.dividend;
                recip_reg <= recip_sel;
            end
            if (mul_pend_reg) begin
                prod_reg <= (mclp_pkg::PROD_W + mclp_pkg::RECIP_W)'(dvd_reg) *
                            (mclp_pkg::PROD_W + mclp_pkg::RECIP_W)'(recip_reg);
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = mclp_pkg::PROD_W'(
        prod_reg[mclp_pkg::PROD_W+mclp_pkg::RECIP_W-1:mclp_pkg::RECIP_SHIFT]);

endmodule

// ===== src/motor_command_line_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// motor_command_line_parser
// Splits command text into lines and turns each valid line into duty,
// mixing, light or direction updates; reports the current outputs per line.
// ============================================================================
//
//  Channel   Ports                          Moves
//  --------  -----------------------------  ------------------------------
//  input     s_valid s_ready s_data         one text byte + packet end flag
//  result    m_valid m_ready m_data         duties, flags, command kind
//  config    cfg_valid cfg_ready cfg_data   pwm_period (13 bit)
//
//  A byte that does not end a line is taken in ST_IDLE. A line end goes to
//  ST_EVAL; ignored, light and direction lines then go to ST_FINISH, a direct
//  duty via ST_MUL and ST_DIV, a steering update via ST_MIX, ST_MUL, ST_DIV,
//  a throttle update via ST_MUL and ST_DIV and then as steering; each product
//  goes through the shared reciprocal divider. s_ready is low while a line
//  is evaluated; it stays high while a finished result waits on m_ready,
//  until the next line end is taken. Reset is synchronous and active low;
//  pwm_period returns to 5000.
module motor_command_line_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mclp_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mclp_pkg::out_item_t               m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mclp_pkg::PERIOD_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_MIX,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_DUTY,
        PH_THROTTLE,
        PH_CUT
    } phase_t;

    state_t                              state_reg;
    phase_t                              phase_reg;

    logic [mclp_pkg::PERIOD_W-1:0]       period_reg;
    logic [mclp_pkg::POS_W-1:0]          pos_reg;
    logic [7:0]                          first_reg;
    logic [7:0]                          cmd_reg;
    logic [7:0]                          chan_reg;
    logic [mclp_pkg::ACC_W-1:0]          acc_reg;
    logic [mclp_pkg::DUTY_W-1:0]         throttle_reg;
    logic [mclp_pkg::STEER_W-1:0]        steering_reg;
    logic [mclp_pkg::DUTY_W-1:0]         duty_a_reg;
    logic [mclp_pkg::DUTY_W-1:0]         duty_b_reg;
    logic                                light_reg;
    logic                                dir_reg;
    logic [mclp_pkg::KIND_W-1:0]         kind_reg;
    logic                                chan_one_reg;
    logic                                mix_hi_reg;
    logic [mclp_pkg::MUL_A_W-1:0]        mul_a_reg;
    logic [mclp_pkg::MUL_B_W-1:0]        mul_b_reg;
    logic [mclp_pkg::DIVISOR_W-1:0]      divisor_reg;
    logic                                m_valid_reg;
    mclp_pkg::out_item_t                 m_data_reg;

    logic                                s_fire;
    logic                                is_nl;
    logic                                is_digit;
    logic [mclp_pkg::ACC_W+3:0]          acc_wide;
    logic [mclp_pkg::ACC_W-1:0]          acc_next;
    logic                                line_ok;
    logic [mclp_pkg::PROD_W-1:0]         cut_ext;
    logic [mclp_pkg::PROD_W-1:0]         thr_ext;
    logic [mclp_pkg::DUTY_W-1:0]         cut_duty;
    logic                                out_free;

    mclp_pkg::div_req_t                  div_req;
    mclp_pkg::div_rsp_t                  div_rsp;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // Character classes and saturating decimal accumulate
    always_comb begin
        is_nl    = (s_data.text_byte == mclp_pkg::CHAR_NL);
        is_digit = (s_data.text_byte >= mclp_pkg::CHAR_ZERO) &&
                   (s_data.text_byte <= mclp_pkg::CHAR_NINE);
        acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} +
                   (mclp_pkg::ACC_W + 4)'(s_data.text_byte - mclp_pkg::CHAR_ZERO);
        acc_next = (acc_wide[mclp_pkg::ACC_W+3:mclp_pkg::ACC_W] != 4'd0) ?
                   '1 : acc_wide[mclp_pkg::ACC_W-1:0];
    end

    // Line qualifies: long enough, starts with 'c', channel '0' or '1'
    assign line_ok = (pos_reg > mclp_pkg::MIN_LEN) && (first_reg == mclp_pkg::CHAR_C) &&
                     ((chan_reg == mclp_pkg::CHAR_ZERO) || (chan_reg == mclp_pkg::CHAR_ONE));

    // Clamp throttle minus cut at zero
    always_comb begin
        cut_ext  = div_rsp.quotient;
        thr_ext  = mclp_pkg::PROD_W'(throttle_reg);
        cut_duty = (cut_ext >= thr_ext) ? '0 :
                   (throttle_reg - div_rsp.quotient[mclp_pkg::DUTY_W-1:0]);
    end

    // Multiply into the divider's dividend register
    always_comb begin
        div_req.start    = (state_reg == ST_MUL);
        div_req.dividend = mclp_pkg::PROD_W'(mul_a_reg) * mclp_pkg::PROD_W'(mul_b_reg);
        div_req.divisor  = divisor_reg;
    end

    mclp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer, line state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= PH_DUTY;
            period_reg   <= mclp_pkg::PERIOD_RESET;
            pos_reg      <= '0;
            first_reg    <= '0;
            cmd_reg      <= '0;
            chan_reg     <= '0;
            acc_reg      <= '0;
            throttle_reg <= '0;
            steering_reg <= '0;
            duty_a_reg   <= '0;
            duty_b_reg   <= '0;
            light_reg    <= 1'b0;
            dir_reg      <= 1'b0;
            kind_reg     <= mclp_pkg::KIND_IGNORED;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                period_reg <= cfg_data;
            end

            // Load the result register at line end, drop it once taken
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (!is_nl) begin
                            if (pos_reg == 8'd0) begin
                                first_reg <= s_data.text_byte;
                            end else if (pos_reg == 8'd1) begin
                                cmd_reg <= s_data.text_byte;
                            end else if (pos_reg == 8'd2) begin
                                chan_reg <= s_data.text_byte;
                            end else if (pos_reg >= mclp_pkg::DIGIT_POS && is_digit) begin
                                acc_reg <= acc_next;
                            end
                            if (pos_reg != '1) begin
                                pos_reg <= pos_reg + 1'b1;
                            end
                        end
                        if (is_nl || s_data.packet_end) begin
                            state_reg <= ST_EVAL;
                        end
                    end
                end

                ST_EVAL: begin
                    // Decode the finished line and clear it for the next one
                    chan_one_reg <= (chan_reg == mclp_pkg::CHAR_ONE);
                    pos_reg      <= '0;
                    first_reg    <= '0;
                    cmd_reg      <= '0;
                    chan_reg     <= '0;
                    acc_reg      <= '0;
                    mul_a_reg    <= acc_reg[mclp_pkg::MUL_A_W-1:0];
                    mul_b_reg    <= mclp_pkg::MUL_B_W'(period_reg);
                    divisor_reg  <= mclp_pkg::SCALE_DIV;
                    if (line_ok && (cmd_reg == mclp_pkg::CHAR_P) &&
                        (acc_reg < mclp_pkg::P_LIMIT)) begin
                        kind_reg  <= mclp_pkg::KIND_IGNORED;
                        phase_reg <= PH_DUTY;
                        state_reg <= ST_MUL;
                    end else if (line_ok && (cmd_reg == mclp_pkg::CHAR_X) &&
                                 (acc_reg < mclp_pkg::X_LIMIT)) begin
                        kind_reg <= mclp_pkg::KIND_IGNORED;
                        if (chan_reg == mclp_pkg::CHAR_ONE) begin
                            steering_reg <= acc_reg[mclp_pkg::STEER_W-1:0];
                            state_reg    <= ST_MIX;
                        end else begin
                            phase_reg <= PH_THROTTLE;
                            state_reg <= ST_MUL;
                        end
                    end else if (line_ok && (cmd_reg == mclp_pkg::CHAR_L)) begin
                        light_reg <= (acc_reg != '0);
                        kind_reg  <= mclp_pkg::KIND_LIGHT;
                        state_reg <= ST_FINISH;
                    end else if (line_ok && (cmd_reg == mclp_pkg::CHAR_D)) begin
                        dir_reg   <= (acc_reg != '0);
                        kind_reg  <= mclp_pkg::KIND_DIR;
                        state_reg <= ST_FINISH;
                    end else begin
                        kind_reg  <= mclp_pkg::KIND_IGNORED;
                        state_reg <= ST_FINISH;
                    end
                end

                ST_MUL: begin
                    state_reg <= ST_DIV;
                end

                ST_DIV: begin
                    if (div_rsp.done) begin
                        case (phase_reg)
                            PH_DUTY: begin
                                if (chan_one_reg) begin
                                    duty_b_reg <= div_rsp.quotient[mclp_pkg::DUTY_W-1:0];
                                end else begin
                                    duty_a_reg <= div_rsp.quotient[mclp_pkg::DUTY_W-1:0];
                                end
                                kind_reg  <= mclp_pkg::KIND_DIRECT;
                                state_reg <= ST_FINISH;
                            end
                            PH_THROTTLE: begin
                                throttle_reg <= div_rsp.quotient[mclp_pkg::DUTY_W-1:0];
                                state_reg    <= ST_MIX;
                            end
                            PH_CUT: begin
                                if (mix_hi_reg) begin
                                    duty_a_reg <= cut_duty;
                                    duty_b_reg <= throttle_reg;
                                end else begin
                                    duty_a_reg <= throttle_reg;
                                    duty_b_reg <= cut_duty;
                                end
                                kind_reg  <= mclp_pkg::KIND_MIXED;
                                state_reg <= ST_FINISH;
                            end
                            default: begin
                                state_reg <= ST_FINISH;
                            end
                        endcase
                    end
                end

                ST_MIX: begin
                    // Cut one side by the steering offset from center
                    mix_hi_reg <= (steering_reg > mclp_pkg::MIX_CENTER);
                    if (steering_reg > mclp_pkg::MIX_CENTER) begin
                        mul_a_reg <= steering_reg - mclp_pkg::MIX_CENTER;
                    end else begin
                        mul_a_reg <= mclp_pkg::MIX_CENTER - steering_reg;
                    end
                    mul_b_reg   <= throttle_reg;
                    divisor_reg <= mclp_pkg::MIX_DIV;
                    phase_reg   <= PH_CUT;
                    state_reg   <= ST_MUL;
                end

                ST_FINISH: begin
                    // Hold until the result register is free
                    if (out_free) begin
                        m_data_reg.duty_a       <= duty_a_reg;
                        m_data_reg.duty_b       <= duty_b_reg;
                        m_data_reg.light_enable <= light_reg;
                        m_data_reg.reverse_dir  <= dir_reg;
                        m_data_reg.command_kind <= kind_reg;
                        state_reg               <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/mclp_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// mclp_checker
// Port-level checks of the motor command line parser, bound to the top level.
// ============================================================================
module mclp_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mclp_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mclp_pkg::out_item_t m_data
);

    // A stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
    else $error("result changed while stalled");

    // A line-ending transfer stops input while the line is evaluated
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_data.packet_end || s_data.text_byte == mclp_pkg::CHAR_NL) |=> !s_ready)
    else $error("input still ready after a line end");

    // Only defined command kinds are reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.command_kind <= mclp_pkg::KIND_DIR)
    else $error("undefined command kind");

    // Reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result valid after reset");

endmodule

bind motor_command_line_parser mclp_checker u_mclp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_motor_command_line_parser.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_motor_command_line_parser
// Self-checking bench for the command line parser. Sends command text as
// byte transfers, tracks line state, duties and flags in a predictor, and
// checks every reported line field by field. A short directed list covers
// each command, the range limits, malformed lines, digit saturation, long
// and empty lines and the period extremes. Random lines follow, mostly
// well-formed commands with random values, mixed with noise and cut-off
// lines. Random idle bursts hit both channels, except in the last phase.
// ============================================================================
module tb_motor_command_line_parser;
    import mclp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_BYTES  = 1440;
    localparam int PHASES        = 6;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    typedef enum int {TERM_NL, TERM_PKT, TERM_NL_PKT, TERM_OPEN} line_end_t;

    // Predicts the report of each finished line and checks the block's reports
    class line_result_scoreboard;
        logic [PERIOD_W-1:0] period;
        logic [POS_W-1:0]    line_pos;
        logic [7:0]          first_char;
        logic [7:0]          cmd_letter;
        logic [7:0]          chan_char;
        logic [ACC_W-1:0]    digit_acc;
        logic [DUTY_W-1:0]   throttle;
        logic [STEER_W-1:0]  steering;
        logic [DUTY_W-1:0]   duty [2];
        logic                light_flag;
        logic                dir_flag;
        out_item_t           expected_reports[$];
        int                  errors;

        function new();
            period     = PERIOD_RESET;
            throttle   = '0;
            steering   = '0;
            duty[0]    = '0;
            duty[1]    = '0;
            light_flag = 1'b0;
            dir_flag   = 1'b0;
            errors     = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_pos   = '0;
            first_char = '0;
            cmd_letter = '0;
            chan_char  = '0;
            digit_acc  = '0;
        endfunction

        function void load_period(logic [PERIOD_W-1:0] value);
            period = value;
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction

        function logic [DUTY_W-1:0] scaled(int unsigned value);
            longint unsigned prod;
            prod = longint'(value) * longint'(period);
            return DUTY_W'(prod / SCALE_DIV);
        endfunction

        // Apply a finished line to the duties and flags, return its kind
        function logic [KIND_W-1:0] run_line();
            int unsigned value;
            int unsigned t;
            int unsigned s;
            int unsigned cut;
            int          ch;
            if (line_pos <= MIN_LEN || first_char != CHAR_C)
                return KIND_IGNORED;
            if (chan_char != CHAR_ZERO && chan_char != CHAR_ONE)
                return KIND_IGNORED;
            ch = (chan_char == CHAR_ONE) ? 1 : 0;
            value = digit_acc;
            if (cmd_letter == CHAR_P) begin
                if (value >= P_LIMIT)
                    return KIND_IGNORED;
                duty[ch] = scaled(value);
                return KIND_DIRECT;
            end else if (cmd_letter == CHAR_X) begin
                if (value >= X_LIMIT)
                    return KIND_IGNORED;
                if (ch == 0)
                    throttle = scaled(value);
                else
                    steering = STEER_W'(value);
                t = throttle;
                s = steering;
                // Cut the inner side of the turn, clamp at zero
                if (s > MIX_CENTER) begin
                    cut = ((s - MIX_CENTER) * t) / MIX_DIV;
                    duty[0] = (cut >= t) ? '0 : DUTY_W'(t - cut);
                    duty[1] = DUTY_W'(t);
                end else begin
                    cut = ((MIX_CENTER - s) * t) / MIX_DIV;
                    duty[0] = DUTY_W'(t);
                    duty[1] = (cut >= t) ? '0 : DUTY_W'(t - cut);
                end
                return KIND_MIXED;
            end else if (cmd_letter == CHAR_L) begin
                light_flag = (value != 0);
                return KIND_LIGHT;
            end else if (cmd_letter == CHAR_D) begin
                dir_flag = (value != 0);
                return KIND_DIR;
            end
            return KIND_IGNORED;
        endfunction

        // Note one accepted byte; queue a report when it ends a line
        function void note_byte(in_item_t item);
            int unsigned acc;
            out_item_t   rpt;
            if (item.text_byte != CHAR_NL) begin
                if (line_pos == 0)
                    first_char = item.text_byte;
                else if (line_pos == 1)
                    cmd_letter = item.text_byte;
                else if (line_pos == 2)
                    chan_char = item.text_byte;
                else if (line_pos >= DIGIT_POS && item.text_byte >= CHAR_ZERO &&
                         item.text_byte <= CHAR_NINE) begin
                    acc = digit_acc;
                    acc = acc * 10 + (item.text_byte - CHAR_ZERO);
                    digit_acc = (acc > {ACC_W{1'b1}}) ? {ACC_W{1'b1}} : ACC_W'(acc);
                end
                if (line_pos != {POS_W{1'b1}})
                    line_pos = line_pos + 1'b1;
                if (!item.packet_end)
                    return;
            end
            rpt.command_kind = run_line();
            clear_line();
            rpt.duty_a       = duty[0];
            rpt.duty_b       = duty[1];
            rpt.light_enable = light_flag;
            rpt.reverse_dir  = dir_flag;
            expected_reports.push_back(rpt);
        endfunction

        function void flag(string what);
            errors++;
            $error("%s", what);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                flag($sformatf("%s: expected %0d, got %0d", field, want, got));
        endfunction

        // Check one accepted report against the oldest expectation
        function void check_report(out_item_t got);
            out_item_t want;
            if (expected_reports.size() == 0) begin
                flag("line report with no expectation waiting");
                return;
            end
            want = expected_reports.pop_front();
            compare("duty_a", 16'(want.duty_a), 16'(got.duty_a));
            compare("duty_b", 16'(want.duty_b), 16'(got.duty_b));
            compare("light_enable", 16'(want.light_enable), 16'(got.light_enable));
            compare("reverse_dir", 16'(want.reverse_dir), 16'(got.reverse_dir));
            compare("command_kind", 16'(want.command_kind), 16'(got.command_kind));
        endfunction

        function void close_out();
            if (expected_reports.size() != 0)
                flag($sformatf("%0d line reports never arrived", expected_reports.size()));
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_item_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_item_t           m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    line_result_scoreboard sb = new();

    logic [7:0] line_buf[$];
    int         sent_bytes  = 0;
    int         cycle_count = 0;
    int         hold_left   = 0;
    bit         idle_on     = 1'b1;
    bit         stall_on    = 1'b1;

    motor_command_line_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= (hold_left == 1);
        end else if (stall_on && $urandom_range(0, 5) == 0) begin
            hold_left <= $urandom_range(1, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watch transfers on all three channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_report(m_data);
            if (s_valid && s_ready)
                sb.note_byte(s_data);
            if (cfg_valid && cfg_ready)
                sb.load_period(cfg_data);
        end
    end

    function automatic logic [7:0] text_char();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_NL);
        return b;
    endfunction

    function automatic logic [7:0] junk_char();
        logic [7:0] b;
        do b = text_char(); while (b >= CHAR_ZERO && b <= CHAR_NINE);
        return b;
    endfunction

    function automatic int unsigned boundary_value();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 999;
            3:       return 1000;
            4:       return 1001;
            5:       return 1023;
            6:       return 1024;
            7:       return 2999;
            8:       return 3000;
            default: return 4095;
        endcase
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    // Append a decimal value, now and then with a leading zero or stray chars
    function automatic void add_number(int unsigned value);
        string digits;
        digits = $sformatf("%0d", value);
        if ($urandom_range(0, 4) == 0)
            line_buf.push_back(CHAR_ZERO);
        for (int i = 0; i < digits.len(); i++) begin
            if ($urandom_range(0, 9) == 0)
                line_buf.push_back(junk_char());
            line_buf.push_back(digits[i]);
        end
    endfunction

    function automatic void add_random_digits(int count);
        repeat (count)
            line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    // Fill line_buf with one random line and pick how it ends
    function automatic void build_random_line(output line_end_t term);
        int unsigned pick;
        int unsigned span;
        logic [7:0]  letter;
        logic [7:0]  chan;
        pick = $urandom_range(0, 299);
        term = line_end_t'($urandom_range(0, 2));
        case ($urandom_range(0, 11))
            0, 1, 2, 3: letter = CHAR_P;
            4, 5, 6, 7: letter = CHAR_X;
            8, 9:       letter = CHAR_L;
            10:         letter = CHAR_D;
            default:    letter = text_char();
        endcase
        chan = $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO;
        if (pick < 230) begin
            // well-formed command with random value
            line_buf.push_back(($urandom_range(0, 24) == 0) ? text_char() : CHAR_C);
            line_buf.push_back(letter);
            line_buf.push_back(($urandom_range(0, 15) == 0) ? text_char() : chan);
            line_buf.push_back(($urandom_range(0, 3) == 0) ? text_char() : CHAR_SPACE);
            span = (letter == CHAR_X) ? 3100 : 1100;
            case ($urandom_range(0, 7))
                0:       add_number($urandom_range(0, 9));
                1, 2:    add_number(boundary_value());
                3:       add_number($urandom_range(0, 99999));
                4:       add_random_digits($urandom_range(7, 12));
                default: add_number($urandom_range(0, span));
            endcase
        end else if (pick < 266) begin
            // raw noise, any byte, any ending
            repeat ($urandom_range(0, 10))
                line_buf.push_back(8'($urandom_range(0, 255)));
            term = line_end_t'($urandom_range(0, 3));
        end else if (pick < 299) begin
            // command cut off before its value
            line_buf.push_back(CHAR_C);
            line_buf.push_back(letter);
            line_buf.push_back(chan);
            line_buf.push_back(CHAR_SPACE);
            repeat ($urandom_range(0, 4))
                void'(line_buf.pop_back());
            if (line_buf.size() == 0)
                term = TERM_NL;
        end else begin
            // overlong line, position counter saturates
            line_buf.push_back(CHAR_C);
            line_buf.push_back(letter);
            line_buf.push_back(chan);
            repeat ($urandom_range(250, 270))
                line_buf.push_back(CHAR_LOWER_A);
            add_number($urandom_range(0, 1100));
        end
    endfunction

    // Present one byte and hold it until the transfer, then maybe idle
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_item_t item;
        item.text_byte = b;
        item.packet_end = last;
        s_data <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_bytes++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10))
                @(posedge aclk);
        end
    endtask

    task automatic send_line(input line_end_t term);
        int n;
        n = line_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(line_buf[i], (term == TERM_PKT) && (i == n - 1));
        if (term == TERM_NL || term == TERM_NL_PKT)
            send_byte(CHAR_NL, term == TERM_NL_PKT);
        line_buf.delete();
    endtask

    task automatic send_text(input string s, input line_end_t term);
        add_text(s);
        send_line(term);
    endtask

    // Drain all reports, let the block settle, then write the period
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        // every command at the reset period
        send_text("cp0 1023", TERM_NL);
        send_text("cp1 0", TERM_PKT);
        send_text("cp0 1024", TERM_NL);
        send_text("cx0 1023", TERM_NL);
        send_text("cx1 2999", TERM_NL_PKT);
        send_text("cx1 1000", TERM_NL);
        send_text("cx0 3000", TERM_NL);
        send_text("cl0 7", TERM_PKT);
        send_text("cd1 99999999999", TERM_NL);
        send_text("cl1 0", TERM_NL);
        // malformed lines
        send_text("cq0 5", TERM_NL);
        send_text("cp0", TERM_NL);
        send_text("cp0 ", TERM_PKT);
        send_text("zp0 5", TERM_NL);
        send_text("cp2 5", TERM_NL);
        send_text("", TERM_NL);
        send_text("", TERM_NL_PKT);
        // byte extremes inside a line
        add_text("cp0");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        add_text("12");
        line_buf.push_back(8'hFF);
        send_line(TERM_PKT);
        // overlong steering line
        add_text("cx1");
        repeat (260)
            line_buf.push_back(CHAR_LOWER_A);
        send_text("1200", TERM_NL);
        // period extremes
        write_period('0);
        send_text("cp1 500", TERM_NL);
        send_text("cx0 2000", TERM_NL);
        write_period({PERIOD_W{1'b1}});
        send_text("cp0 1023", TERM_NL);
        send_text("cx0 2999", TERM_NL);
        write_period(PERIOD_W'(1));
        send_text("cp1 1023", TERM_PKT);
    endtask

    initial begin
        logic [PERIOD_W-1:0] period_val;
        int                  phase_end;
        line_end_t           term;
        repeat (8)
            @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       period_val = PERIOD_W'($urandom_range(1, 8191));
                1:       period_val = PERIOD_W'(1023);
                2:       period_val = {PERIOD_W{1'b1}};
                3:       period_val = PERIOD_W'(1);
                4:       period_val = PERIOD_W'($urandom_range(0, 8191));
                default: period_val = PERIOD_RESET;
            endcase
            write_period(period_val);
            // quiet final phase: no idling on either side
            if (ph == PHASES - 1) begin
                idle_on = 1'b0;
                stall_on = 1'b0;
            end
            phase_end = sent_bytes + RANDOM_BYTES / PHASES;
            while (sent_bytes < phase_end) begin
                build_random_line(term);
                send_line(term);
            end
            send_text("", TERM_NL);
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES)
            @(posedge aclk);
        sb.close_out();
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
